// ----- rtl/wcpm_pkg.sv -----
// Package: types, constants and sequencer states of the cosine pattern matcher.
package wcpm_pkg;

   localparam int MaxWindow   = 256;
   localparam int SampleWidth = 16;
   localparam int PatAddrBits = $clog2(MaxWindow);
   localparam int LenBits     = PatAddrBits + 1;
   localparam int AccBits     = 40;
   localparam int ThrBits     = 15;

   localparam logic [LenBits-1:0] LenReset = LenBits'(MaxWindow);
   localparam logic [ThrBits-1:0] ThrReset = 15'd32440;   // 0.99 in Q1.15

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic CSR_WINDOW_LENGTH   = 1'b0;
   localparam logic CSR_MATCH_THRESHOLD = 1'b1;

   typedef struct packed {
      logic                          req_type;
      logic [7:0]                    pattern_index;
      logic signed [SampleWidth-1:0] sample_value;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] similarity;
      logic               is_match;
      logic [31:0]        window_number;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC_PX,
      ST_ACC_PP,
      ST_ACC_XX,
      ST_SETUP,
      ST_SQ,
      ST_EE,
      ST_DIV,
      ST_SQRT,
      ST_RESULT
   } state_type;

endpackage

// ----- rtl/windowed_cosine_pattern_match_top.sv -----
// Top level: windowed cosine-similarity pattern matcher with shared iterative arithmetic.
//
// A load request (req_type 0) writes one pattern element. A sample request (req_type 1)
// makes one pattern read, then three passes through a single 17x17 multiplier for
// pattern*sample, pattern^2 and sample^2. On the sample that closes a window the same
// sequencer works out the Q1.15 similarity: a setup step, shift-add to square the dot
// magnitude, more shift-add for the energy product, 31 restoring-divide steps and 16
// square-root steps, then a result step that posts it. A saturating similarity skips
// the divide and root steps, and a zero energy goes straight from setup to the result;
// the result step waits while an earlier response is still stalled. The block takes no
// request while it works on one; a posted response sits in its own register, so the
// next request is taken while it waits. The configuration port is always ready; the
// user must write it only while the block is idle, which the block itself does not enforce.
module windowed_cosine_pattern_match_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wcpm_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wcpm_pkg::rsp_item_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [14:0]           csr_wdata
);

   localparam int LB = wcpm_pkg::LenBits;
   localparam int AB = wcpm_pkg::AccBits;
   localparam int SW = wcpm_pkg::SampleWidth;
   localparam int PB = 2 * AB;

   wcpm_pkg::state_type state_ff, state_in;

   logic signed [SW-1:0] x_ff, x_in;
   logic signed [SW-1:0] pat_rd_ff;
   logic [LB-1:0]        pos_ff, pos_in;
   logic [AB-1:0]        dot_ff, dot_in, ep_ff, ep_in, ew_ff, ew_in;
   logic [31:0]          wcnt_ff, wcnt_in;
   logic [LB-1:0]        len_ff;
   logic [14:0]          thr_ff;
   logic                 neg_ff, neg_in, sat_ff, sat_in, zero_ff, zero_in;
   logic [PB-1:0]        mcand_ff, mcand_in, prod_ff, prod_in, num_ff, num_in;
   logic [AB-1:0]        mplier_ff, mplier_in;
   logic [PB-1:0]        rem_ff, rem_in;
   logic [30:0]          low_ff, low_in, quo_ff, quo_in;
   logic [15:0]          root_ff, root_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   wcpm_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic signed [SW-1:0] pattern_mem [wcpm_pkg::MaxWindow];

   logic                 req_take, load_take, sample_take, out_free;
   logic signed [SW:0]   mul_a, mul_b;
   logic signed [2*SW+1:0] mul_p;
   logic [AB-1:0]        prod40;
   logic [PB-1:0]        sa_sum;
   logic [LB-1:0]        eff_len, pos_next;
   logic                 win_end;
   logic [AB-1:0]        mag;
   logic [PB:0]          div_sh;
   logic                 div_ge;
   logic [15:0]          trial;
   logic [16:0]          hi_lim, lo_val, root_ext;
   logic [15:0]          res_sim;
   logic                 res_match;

   assign req_stall = (state_ff != wcpm_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_take    = req_valid && !req_stall;
   assign load_take   = req_take && (req_data.req_type == wcpm_pkg::REQ_LOAD);
   assign sample_take = req_take && (req_data.req_type == wcpm_pkg::REQ_SAMPLE);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // Shared 17x17 multiplier: products for accumulation, trial squares for the root.
   assign mul_p  = mul_a * mul_b;
   assign prod40 = AB'(mul_p);
   // Shared shift-add step for the two wide products.
   assign sa_sum = prod_ff + (mplier_ff[0] ? mcand_ff : '0);

   // Clamp the window length: zero acts as one, above the store depth acts as its depth.
   assign eff_len  = (len_ff == '0) ? LB'(1) :
                     (len_ff > LB'(wcpm_pkg::MaxWindow)) ? LB'(wcpm_pkg::MaxWindow) : len_ff;
   assign pos_next = pos_ff + LB'(1);
   assign win_end  = (pos_next >= eff_len);

   assign mag    = dot_ff[AB-1] ? (AB'(0) - dot_ff) : dot_ff;
   assign div_sh = {rem_ff, low_ff[30]};
   assign div_ge = (div_sh >= {1'b0, prod_ff});
   assign trial  = root_ff | (16'd1 << cnt_ff[3:0]);

   assign hi_lim   = neg_ff ? 17'd32768 : 17'd32767;
   assign root_ext = {1'b0, root_ff};
   assign lo_val   = zero_ff ? 17'd0 :
                     sat_ff ? hi_lim :
                     (root_ext > hi_lim) ? hi_lim : root_ext;
   assign res_sim   = neg_ff ? 16'(17'd0 - lo_val) : lo_val[15:0];
   assign res_match = ($signed({res_sim[15], res_sim}) > $signed({2'b00, thr_ff}));

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      pos_in       = pos_ff;
      dot_in       = dot_ff;
      ep_in        = ep_ff;
      ew_in        = ew_ff;
      wcnt_in      = wcnt_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      zero_in      = zero_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      quo_in       = quo_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mul_a        = {pat_rd_ff[SW-1], pat_rd_ff};
      mul_b        = {x_ff[SW-1], x_ff};

      unique case (state_ff)
         wcpm_pkg::ST_IDLE: begin
            if (sample_take) begin
               x_in     = req_data.sample_value;
               state_in = wcpm_pkg::ST_ACC_PX;
            end
         end
         wcpm_pkg::ST_ACC_PX: begin
            dot_in   = dot_ff + prod40;
            state_in = wcpm_pkg::ST_ACC_PP;
         end
         wcpm_pkg::ST_ACC_PP: begin
            mul_b    = {pat_rd_ff[SW-1], pat_rd_ff};
            ep_in    = ep_ff + prod40;
            state_in = wcpm_pkg::ST_ACC_XX;
         end
         wcpm_pkg::ST_ACC_XX: begin
            mul_a = {x_ff[SW-1], x_ff};
            ew_in = ew_ff + prod40;
            if (win_end) begin
               pos_in   = '0;
               state_in = wcpm_pkg::ST_SETUP;
            end else begin
               pos_in   = pos_next;
               state_in = wcpm_pkg::ST_IDLE;
            end
         end
         wcpm_pkg::ST_SETUP: begin
            neg_in    = dot_ff[AB-1];
            zero_in   = (ep_ff == '0) || (ew_ff == '0);
            sat_in    = 1'b0;
            mcand_in  = {{AB{1'b0}}, mag};
            mplier_in = mag;
            prod_in   = '0;
            cnt_in    = 6'(AB - 1);
            state_in  = zero_in ? wcpm_pkg::ST_RESULT : wcpm_pkg::ST_SQ;
         end
         wcpm_pkg::ST_SQ: begin
            prod_in   = sa_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               // Hold dot^2, start the energy product.
               num_in    = sa_sum;
               prod_in   = '0;
               mcand_in  = {{AB{1'b0}}, ep_ff};
               mplier_in = ew_ff;
               cnt_in    = 6'(AB - 1);
               state_in  = wcpm_pkg::ST_EE;
            end
         end
         wcpm_pkg::ST_EE: begin
            prod_in   = sa_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               // Dividend is dot^2 * 2^30; quotient of 2^31 or more saturates.
               sat_in   = ({1'b0, num_ff[PB-1:1]} >= sa_sum);
               rem_in   = {1'b0, num_ff[PB-1:1]};
               low_in   = {num_ff[0], 30'd0};
               quo_in   = '0;
               cnt_in   = 6'd30;
               state_in = sat_in ? wcpm_pkg::ST_RESULT : wcpm_pkg::ST_DIV;
            end
         end
         wcpm_pkg::ST_DIV: begin
            rem_in = div_ge ? PB'(div_sh - {1'b0, prod_ff}) : div_sh[PB-1:0];
            quo_in = {quo_ff[29:0], div_ge};
            low_in = low_ff << 1;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               root_in  = '0;
               cnt_in   = 6'd15;
               state_in = wcpm_pkg::ST_SQRT;
            end
         end
         wcpm_pkg::ST_SQRT: begin
            mul_a = {1'b0, trial};
            mul_b = {1'b0, trial};
            if (mul_p[32:0] <= {2'b00, quo_ff}) begin
               root_in = trial;
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               state_in = wcpm_pkg::ST_RESULT;
            end
         end
         wcpm_pkg::ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.similarity    = res_sim;
               rsp_data_in.is_match      = res_match;
               rsp_data_in.window_number = wcnt_ff;
               wcnt_in                   = wcnt_ff + 32'd1;
               dot_in                    = '0;
               ep_in                     = '0;
               ew_in                     = '0;
               state_in                  = wcpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wcpm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wcpm_pkg::ST_IDLE;
         pos_ff       <= '0;
         dot_ff       <= '0;
         ep_ff        <= '0;
         ew_ff        <= '0;
         wcnt_ff      <= '0;
         len_ff       <= wcpm_pkg::LenReset;
         thr_ff       <= wcpm_pkg::ThrReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         dot_ff       <= dot_in;
         ep_ff        <= ep_in;
         ew_ff        <= ew_in;
         wcnt_ff      <= wcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               wcpm_pkg::CSR_WINDOW_LENGTH:   len_ff <= csr_wdata[LB-1:0];
               wcpm_pkg::CSR_MATCH_THRESHOLD: thr_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Datapath registers: no reset needed.
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      neg_ff      <= neg_in;
      sat_ff      <= sat_in;
      zero_ff     <= zero_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      quo_ff      <= quo_in;
      root_ff     <= root_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Pattern store: write on load, read the current window position on a sample.
   always_ff @(posedge clock) begin
      if (load_take) begin
         pattern_mem[req_data.pattern_index[wcpm_pkg::PatAddrBits-1:0]] <= req_data.sample_value;
      end
      if (sample_take) begin
         pat_rd_ff <= pattern_mem[pos_ff[wcpm_pkg::PatAddrBits-1:0]];
      end
   end

   // Posting a result advances the window count by exactly one.
   a_wcnt_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcpm_pkg::ST_RESULT && out_free) |=> (wcnt_ff == $past(wcnt_ff) + 32'd1))
      else $error("window count did not advance on result");

   // The window position restarts before the similarity work begins.
   a_pos_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcpm_pkg::ST_SETUP) |-> (pos_ff == '0))
      else $error("window position not cleared at window end");

   // A zero energy always yields a zero similarity.
   a_zero_sim: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcpm_pkg::ST_RESULT && zero_ff) |-> (res_sim == 16'd0 && !res_match))
      else $error("zero energy gave nonzero similarity");

   // A nonnegative dot product never yields a negative similarity.
   a_sim_sign: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcpm_pkg::ST_RESULT && !neg_ff) |-> !res_sim[15])
      else $error("nonnegative dot gave negative similarity");

   // Accumulators are cleared in the cycle after a result posts.
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcpm_pkg::ST_RESULT && out_free) |=> (dot_ff == '0 && ep_ff == '0 && ew_ff == '0))
      else $error("accumulators not cleared after result");

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the windowed cosine-similarity pattern matcher.
`timescale 1ns / 1ps

module tb_top;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   wcpm_pkg::req_item_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   wcpm_pkg::rsp_item_type rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_index = wcpm_pkg::CSR_WINDOW_LENGTH;
   logic [14:0]            csr_wdata = '0;

   windowed_cosine_pattern_match_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Requests waiting for the driver, and window scores still owed by the block.
   wcpm_pkg::req_item_type pending_reqs[$];
   wcpm_pkg::rsp_item_type score_queue[$];
   int                     fail_count = 0;

   // Shadow of the matcher, advanced when a request is accepted.
   logic signed [15:0] shadow_pattern[wcpm_pkg::MaxWindow];
   logic [39:0]        shadow_dot, shadow_pat_energy, shadow_win_energy;
   logic [8:0]         shadow_pos;
   logic [31:0]        shadow_window_count;
   logic [8:0]         shadow_len;
   logic [14:0]        shadow_thr;

   // Exact Q1.15 cosine: largest m with m^2*Ep*Ew <= dot^2*2^30, sign from dot.
   function automatic logic signed [15:0] cosine_q15(logic [39:0] d, logic [39:0] ep,
                                                     logic [39:0] ew);
      logic         neg;
      logic [39:0]  mag;
      logic [127:0] rhs, lhs;
      int           lo, hi, mid;
      if (ep == 0 || ew == 0) return 16'sd0;
      neg = d[39];
      mag = neg ? (~d + 40'd1) : d;
      rhs = ({88'd0, mag} * {88'd0, mag}) << 30;
      lo = 0;
      hi = neg ? 32768 : 32767;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         lhs = 128'(mid) * 128'(mid) * {88'd0, ep} * {88'd0, ew};
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return neg ? 16'(-lo) : 16'(lo);
   endfunction

   // Advance the shadow by one accepted request; queue a score on a window's end.
   function automatic void score_request(wcpm_pkg::req_item_type r);
      logic signed [15:0]     p;
      logic [8:0]             eff_len;
      wcpm_pkg::rsp_item_type s;
      if (r.req_type == wcpm_pkg::REQ_LOAD) begin
         shadow_pattern[r.pattern_index] = r.sample_value;
         return;
      end
      eff_len = (shadow_len == 0) ? 9'd1 :
                (shadow_len > wcpm_pkg::MaxWindow) ? 9'(wcpm_pkg::MaxWindow) : shadow_len;
      p = shadow_pattern[shadow_pos[7:0]];
      shadow_dot        += 40'(64'(p) * 64'(r.sample_value));
      shadow_pat_energy += 40'(64'(p) * 64'(p));
      shadow_win_energy += 40'(64'(r.sample_value) * 64'(r.sample_value));
      shadow_pos++;
      if (shadow_pos < eff_len) return;
      s.similarity    = cosine_q15(shadow_dot, shadow_pat_energy, shadow_win_energy);
      s.is_match      = (s.similarity > $signed({1'b0, shadow_thr}));
      s.window_number = shadow_window_count;
      score_queue = {score_queue, s};
      shadow_window_count++;
      shadow_pos = 0;
      shadow_dot = 0;
      shadow_pat_energy = 0;
      shadow_win_energy = 0;
   endfunction

   // Mostly short idles, a few long ones; a calm mode switches idling off for a while.
   function automatic int idle_length(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Driver: hold the request while stalled, advance on acceptance.
   int drv_gap = 0;
   bit drv_calm = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) score_request(req_data);
         if ($urandom_range(0, 149) == 0) drv_calm = !drv_calm;
         if (drv_gap > 0) begin
            drv_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            drv_gap   = idle_length(drv_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each accepted score against the oldest one owed, then pick a stall.
   int mon_gap = 0;
   bit mon_calm = 0;
   wcpm_pkg::rsp_item_type want;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (score_queue.size() == 0) begin
               $display("%0t: unexpected score, expected none, actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = score_queue.pop_front();
               if (rsp_data.similarity !== want.similarity) begin
                  $display("%0t: similarity expected %0d actual %0d", $time,
                           want.similarity, rsp_data.similarity);
                  fail_count++;
               end
               if (rsp_data.is_match !== want.is_match) begin
                  $display("%0t: is_match expected %0d actual %0d", $time,
                           want.is_match, rsp_data.is_match);
                  fail_count++;
               end
               if (rsp_data.window_number !== want.window_number) begin
                  $display("%0t: window_number expected %0d actual %0d", $time,
                           want.window_number, rsp_data.window_number);
                  fail_count++;
               end
            end
         end
         if ($urandom_range(0, 149) == 0) mon_calm = !mon_calm;
         if (mon_gap > 0) begin
            mon_gap--;
            rsp_stall <= 1'b1;
         end else begin
            mon_gap   = idle_length(mon_calm);
            rsp_stall <= (mon_gap > 0);
         end
      end
   end

   // Generator-side mirror of the pattern and window position, used to build
   // windows that line up with the stored pattern.
   logic signed [15:0] gen_pattern[wcpm_pkg::MaxWindow];
   int                 gen_pos = 0;
   int                 gen_len = wcpm_pkg::MaxWindow;

   function automatic logic signed [15:0] any_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sd0;
         3: return 16'($urandom_range(0, 15)) - 16'sd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void push_load(int idx, logic signed [15:0] v);
      wcpm_pkg::req_item_type r;
      r.req_type      = wcpm_pkg::REQ_LOAD;
      r.pattern_index = 8'(idx);
      r.sample_value  = v;
      gen_pattern[idx] = v;
      pending_reqs = {pending_reqs, r};
   endfunction

   function automatic void push_sample(logic signed [15:0] v);
      wcpm_pkg::req_item_type r;
      int                     eff;
      r.req_type      = wcpm_pkg::REQ_SAMPLE;
      r.pattern_index = 8'($urandom);   // ignored on samples, toggle it anyway
      r.sample_value  = v;
      pending_reqs = {pending_reqs, r};
      eff = (gen_len == 0) ? 1 : (gen_len > wcpm_pkg::MaxWindow) ? wcpm_pkg::MaxWindow : gen_len;
      gen_pos++;
      if (gen_pos >= eff) gen_pos = 0;
   endfunction

   // One window's worth of samples from the current position, shaped by a mode.
   function automatic void push_window(int mode, int count);
      logic signed [15:0] p, v;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 11) == 0) push_load($urandom_range(0, 255), any_sample());
         p = gen_pattern[gen_pos];
         case (mode)
            0: v = p;                                           // identical
            1: v = (p == 16'sh8000) ? 16'sh7FFF : -p;           // anti-correlated
            2: v = p >>> 1;                                     // scaled copy
            3: v = p + 16'($urandom_range(0, 63)) - 16'sd32;    // noisy copy
            4: v = 16'sd0;                                      // zero window energy
            default: v = any_sample();                          // unrelated
         endcase
         push_sample(v);
      end
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || score_queue.size() > 0);
      // a last sample that closes no window may still be accumulating after the last score
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 15'(value);
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == wcpm_pkg::CSR_WINDOW_LENGTH) begin
         shadow_len = 9'(value);
         gen_len    = value & 9'h1FF;
      end else begin
         shadow_thr = 15'(value);
      end
   endtask

   int phase_len[9] = '{1, 0, 5, 300, 3, 16, 2, 64, 7};
   int phase_thr[9] = '{0, 32767, 100, 32440, 20000, 32767, 0, 30000, 32000};
   int budget;

   initial begin
      for (int i = 0; i < wcpm_pkg::MaxWindow; i++) shadow_pattern[i] = 16'sd0;
      shadow_dot = 0; shadow_pat_energy = 0; shadow_win_energy = 0;
      shadow_pos = 0; shadow_window_count = 0;
      shadow_len = wcpm_pkg::LenReset; shadow_thr = wcpm_pkg::ThrReset;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole pattern first so that no sample reads an unwritten entry.
      push_load(0, 16'sh8000);
      push_load(1, 16'sh7FFF);
      for (int i = 2; i < wcpm_pkg::MaxWindow; i++) push_load(i, any_sample());
      // Full-length window at reset settings, identical to the pattern.
      push_window(0, wcpm_pkg::MaxWindow);
      wait_idle();

      // Short directed windows: zero pattern energy, saturation both ways, zero samples.
      write_csr(wcpm_pkg::CSR_WINDOW_LENGTH, 2);
      write_csr(wcpm_pkg::CSR_MATCH_THRESHOLD, 32767);
      push_load(0, 16'sd0); push_load(1, 16'sd0);
      push_window(5, 2);                                 // pattern energy zero
      push_load(0, 16'sh7FFF); push_load(1, 16'sh7FFF);
      push_sample(16'sh7FFF); push_sample(16'sh7FFF);    // positive saturation
      push_sample(16'sh8000); push_sample(16'sh8000);    // negative extreme
      push_window(4, 2);                                 // window energy zero
      push_load(1, 16'sh8000);
      push_sample(16'sh7FFF); push_sample(16'sh8000);
      wait_idle();

      // Random phases; each ends with the pipe drained before the next setting.
      for (int ph = 0; ph < 9; ph++) begin
         write_csr(wcpm_pkg::CSR_WINDOW_LENGTH, phase_len[ph]);
         write_csr(wcpm_pkg::CSR_MATCH_THRESHOLD, phase_thr[ph]);
         budget = (phase_len[ph] > wcpm_pkg::MaxWindow) ? 10 : 14;
         while (budget > 0) begin
            int eff;
            eff = (gen_len == 0) ? 1 :
                  (gen_len > wcpm_pkg::MaxWindow) ? wcpm_pkg::MaxWindow : gen_len;
            if ($urandom_range(0, 19) == 0)
               for (int k = 0; k < eff; k++) push_load(k, 16'sd0);
            if (eff > budget) eff = budget;
            push_window($urandom_range(0, 7), eff);
            budget -= eff;
         end
         // Re-randomize the region used by short windows so zero patterns do not linger.
         for (int k = 0; k < 16; k++)
            if (gen_pattern[k] == 16'sd0) push_load(k, any_sample());
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("windowed_cosine_pattern_match_top regression: pass");
      end else begin
         $display("windowed_cosine_pattern_match_top regression: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("windowed_cosine_pattern_match_top regression: fail");
      $finish;
   end

endmodule
